// File: hw/rtl/assert_macros.svh
// assertion macros for the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, masked while reset is held
`define CPE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// clocked check, also active during reset
`define CPE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: hw/rtl/cpe_pkg.sv
// package: constants and types for the channel payload extractor
package cpe_pkg;

  // packet positions and limits
  localparam int unsigned POS_W            = 16;
  localparam int unsigned MAX_PACKET_BYTES = 65535;
  localparam int unsigned HDR_BYTES        = 16;
  localparam int unsigned TIME_BYTES       = 8;
  localparam int unsigned POS_CNT_LO       = 8;
  localparam int unsigned POS_CNT_HI       = 9;
  localparam int unsigned POS_FIRST_LO     = 10;
  localparam int unsigned POS_FIRST_HI     = 11;
  localparam int unsigned POS_PAD_START    = 12;

  // field widths
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned TIME_W  = 64;
  localparam int unsigned OUT_W   = 72;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [POS_W-1:0]  pos_t;
  typedef logic [TIME_W-1:0] stamp_t;
  typedef logic [OUT_W-1:0]  out_data_t;

endpackage

// File: hw/rtl/channel_payload_extractor.sv
// channel payload extractor: parses a multichannel packet and forwards one channel
//
//  channel | direction | ports                      | contents
//  --------+-----------+----------------------------+-------------------------------
//  in      | input     | in_tvalid/tready/tdata/tlast | raw packet byte, end of packet
//  out     | output    | out_tvalid/tready/tdata/tlast/tuser | payload byte + timestamp
//  cfg     | input     | cfg_wr_en/cfg_wr_data       | channel_select register
//
// one item per cycle while in_tready is high; the packet state and any result
// are written at the accepting edge, so a result is offered from the next cycle on.
// in_tready is high whenever the output register is empty or being drained.
// synchronous active-low reset clears all packet state and channel_select.
// a stall on out_tready holds the result and stops input only while it is held.
module channel_payload_extractor (
  input  logic              clk,
  input  logic              rst_n,
  // input channel
  input  logic              in_tvalid,
  output logic              in_tready,
  input  cpe_pkg::byte_t    in_tdata,     // [7:0] data_byte
  input  logic              in_tlast,     // end_of_packet
  // result channel
  output logic              out_tvalid,
  input  logic              out_tready,
  output cpe_pkg::out_data_t out_tdata,   // [7:0] payload_byte, [71:8] timestamp
  output logic              out_tlast,    // is_last
  output logic [0:0]        out_tuser,    // [0] truncated
  // configuration
  input  logic              cfg_wr_en,
  input  cpe_pkg::byte_t    cfg_wr_data   // channel_select
);
  import cpe_pkg::*;
  `include "assert_macros.svh"

  // registers
  byte_t  chan_sel_r;
  pos_t   pos_r,        pos_nxt;
  stamp_t hdr_time_r,   hdr_time_nxt;
  pos_t   chan_cnt_r,   chan_cnt_nxt;
  pos_t   first_ch_r,   first_ch_nxt;
  byte_t  low_hold_r,   low_hold_nxt;
  pos_t   tbl_entry_r,  tbl_entry_nxt;
  pos_t   data_start_r, data_start_nxt;
  pos_t   pay_len_r,    pay_len_nxt;
  logic   drop_r,       drop_nxt;

  logic   out_valid_r,  out_valid_nxt;
  byte_t  out_byte_r,   out_byte_nxt;
  stamp_t out_time_r,   out_time_nxt;
  logic   out_last_r,   out_last_nxt;
  logic   out_trunc_r,  out_trunc_nxt;

  // combinational helpers
  logic          in_accept;
  logic [17:0]   tbl_end;
  logic [17:0]   pos_ext;
  logic          sel_ge;
  pos_t          rel;
  logic          entry_lt;
  logic          entry_eq;
  pos_t          len;
  logic [16:0]   sum;
  pos_t          first_new;
  logic [16:0]   range_end;
  logic          in_range;
  logic [16:0]   pay_end;
  logic [16:0]   pos_p1;
  logic          in_payload;
  logic          complete;

  assign in_tready = !out_valid_r || out_tready;
  assign in_accept = in_tvalid && in_tready;

  // table bounds and channel offset
  assign tbl_end   = 18'(HDR_BYTES) + {1'b0, chan_cnt_r, 1'b0};
  assign pos_ext   = {2'b00, pos_r};
  assign sel_ge    = {8'h00, chan_sel_r} >= first_ch_r;
  assign rel       = {8'h00, chan_sel_r} - first_ch_r;
  assign entry_lt  = !sel_ge || (tbl_entry_r < rel);
  assign entry_eq  = sel_ge && (tbl_entry_r == rel);
  assign len       = {in_tdata, low_hold_r};
  assign sum       = {1'b0, data_start_r} + {1'b0, len};

  // header check values
  assign first_new = {in_tdata, first_ch_r[7:0]};
  assign range_end = {1'b0, first_new} + {1'b0, chan_cnt_r};
  assign in_range  = ({8'h00, chan_sel_r} >= first_new) &&
                     ({9'd0, chan_sel_r} < range_end);

  // payload window
  assign pay_end    = {1'b0, data_start_r} + {1'b0, pay_len_r};
  assign pos_p1     = {1'b0, pos_r} + 17'd1;
  assign in_payload = (pos_r >= data_start_r) && ({1'b0, pos_r} < pay_end);
  assign complete   = (pos_p1 == pay_end);

  // next-state logic for one accepted item
  always_comb begin
    pos_nxt        = pos_r;
    hdr_time_nxt   = hdr_time_r;
    chan_cnt_nxt   = chan_cnt_r;
    first_ch_nxt   = first_ch_r;
    low_hold_nxt   = low_hold_r;
    tbl_entry_nxt  = tbl_entry_r;
    data_start_nxt = data_start_r;
    pay_len_nxt    = pay_len_r;
    drop_nxt       = drop_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_byte_nxt   = out_byte_r;
    out_time_nxt   = out_time_r;
    out_last_nxt   = out_last_r;
    out_trunc_nxt  = out_trunc_r;

    if (in_accept) begin
      out_valid_nxt = 1'b0;
      if (pos_r != pos_t'(MAX_PACKET_BYTES)) begin
        if (pos_r < pos_t'(TIME_BYTES)) begin
          hdr_time_nxt[{pos_r[2:0], 3'b000} +: 8] = in_tdata;
        end else if (pos_r == pos_t'(POS_CNT_LO)) begin
          chan_cnt_nxt[7:0] = in_tdata;
        end else if (pos_r == pos_t'(POS_CNT_HI)) begin
          chan_cnt_nxt[15:8] = in_tdata;
        end else if (pos_r == pos_t'(POS_FIRST_LO)) begin
          first_ch_nxt[7:0] = in_tdata;
        end else if (pos_r == pos_t'(POS_FIRST_HI)) begin
          // header complete: check channel range and set data start to the table end
          first_ch_nxt = first_new;
          if (!in_range) begin
            drop_nxt = 1'b1;
          end else begin
            if (tbl_end[17:16] != 2'b00) begin
              drop_nxt = 1'b1;
            end else begin
              data_start_nxt = tbl_end[15:0];
            end
            tbl_entry_nxt = '0;
            pay_len_nxt   = '0;
          end
        end else if (!drop_r && pos_r >= pos_t'(HDR_BYTES) && pos_ext < tbl_end) begin
          // length table: low byte first, then accumulate or capture
          if (!pos_r[0]) begin
            low_hold_nxt = in_tdata;
          end else begin
            if (entry_lt) begin
              if (sum[16]) begin
                drop_nxt = 1'b1;
              end else begin
                data_start_nxt = sum[15:0];
              end
            end else if (entry_eq) begin
              pay_len_nxt = len;
            end
            tbl_entry_nxt = tbl_entry_r + 16'd1;
          end
        end else if (!drop_r && pos_r >= pos_t'(POS_PAD_START)) begin
          // payload byte of the selected channel
          if (in_payload) begin
            out_valid_nxt = 1'b1;
            out_byte_nxt  = in_tdata;
            out_time_nxt  = hdr_time_r;
            out_last_nxt  = complete || in_tlast;
            out_trunc_nxt = in_tlast && !complete;
          end
        end
        pos_nxt = pos_r + 16'd1;
      end

      // end of packet clears the packet state but not the timestamp or the result
      if (in_tlast) begin
        pos_nxt        = '0;
        chan_cnt_nxt   = '0;
        first_ch_nxt   = '0;
        low_hold_nxt   = '0;
        tbl_entry_nxt  = '0;
        data_start_nxt = '0;
        pay_len_nxt    = '0;
        drop_nxt       = 1'b0;
      end
    end
  end

  // state and output registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_sel_r   <= '0;
      pos_r        <= '0;
      hdr_time_r   <= '0;
      chan_cnt_r   <= '0;
      first_ch_r   <= '0;
      low_hold_r   <= '0;
      tbl_entry_r  <= '0;
      data_start_r <= '0;
      pay_len_r    <= '0;
      drop_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        chan_sel_r <= cfg_wr_data;
      end
      pos_r        <= pos_nxt;
      hdr_time_r   <= hdr_time_nxt;
      chan_cnt_r   <= chan_cnt_nxt;
      first_ch_r   <= first_ch_nxt;
      low_hold_r   <= low_hold_nxt;
      tbl_entry_r  <= tbl_entry_nxt;
      data_start_r <= data_start_nxt;
      pay_len_r    <= pay_len_nxt;
      drop_r       <= drop_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    out_byte_r  <= out_byte_nxt;
    out_time_r  <= out_time_nxt;
    out_last_r  <= out_last_nxt;
    out_trunc_r <= out_trunc_nxt;
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = {out_time_r, out_byte_r};
  assign out_tlast    = out_last_r;
  assign out_tuser[0] = out_trunc_r;

  // checks
  `CPE_ASSERT(a_trunc_is_last, out_valid_r && out_trunc_r |-> out_last_r, "truncated without last")
  `CPE_ASSERT(a_new_result_from_item, $rose(out_valid_r) |-> $past(in_accept), "result without item")
  `CPE_ASSERT(a_eop_clears, in_accept && in_tlast |=> pos_r == '0 && !drop_r && tbl_entry_r == '0, "packet state not cleared")
  `CPE_ASSERT(a_pos_saturates, in_accept && !in_tlast && pos_r == pos_t'(MAX_PACKET_BYTES) |=> pos_r == pos_t'(MAX_PACKET_BYTES), "position wrapped")

endmodule
